/* rtl/cbz_pkg.sv */
// ----------------------------------------------------------------------------
// cbz_pkg - shared types and constants of the cubic bezier point evaluator
// Field widths, the pipeline stage count and the register index codes.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // control point and result formats
  localparam int POINT_W = 16;
  localparam int COORD_W = 32;

  // power-basis coefficients of the curve fit in this many bits, signed
  localparam int COEF_W = 20;

  // wide multiplies are cut into chunks of this many bits of the multiplicand
  localparam int MUL_CHUNK_W = 24;

  // input register, three multiply stages, three add stages
  localparam int NUM_STAGES = 7;

  localparam int CFG_INDEX_W = 3;

  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_POINT_0 = 3'd0,
    REG_X_POINT_1 = 3'd1,
    REG_X_POINT_2 = 3'd2,
    REG_X_POINT_3 = 3'd3,
    REG_Y_POINT_0 = 3'd4,
    REG_Y_POINT_1 = 3'd5,
    REG_Y_POINT_2 = 3'd6,
    REG_Y_POINT_3 = 3'd7
  } cfg_reg_t;

endpackage

/* rtl/cubic_bezier_point_eval.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval - cubic bezier curve point evaluator
// Evaluates x and y of a cubic bezier curve at t = index / 2^SAMPLE_BITS.
// ----------------------------------------------------------------------------
// Each sample transfer carries an index i; only its low SAMPLE_BITS bits are
// used, so t = i / 2^SAMPLE_BITS lies in [0,1). The four control points per
// axis are written through the config port (indexes 0..3 are x, 4..7 are y,
// reset to zero) and must only change while no sample is in flight. The
// bernstein form is rewritten in power basis and evaluated by horner's rule
// with exact integer arithmetic; the result is floored to signed Q16.16.
// Throughput is one sample per cycle while results are taken. There are 7
// register stages: an input register, then three multiply/add stage pairs
// of the horner chain (wide multiplies split into 24-bit chunk products).
// The result is held in the last add stage's register. Every stage has its
// own valid bit and enable, so a stalled result only holds the stages behind
// it once they are full, and empty stages keep taking new samples.
module cubic_bezier_point_eval #(
  parameter int SAMPLE_BITS = 19
) (
  input  logic                                 clk,
  input  logic                                 rst,

  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic [SAMPLE_BITS-1:0]               sample_index,

  // result channel
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [cbz_pkg::COORD_W-1:0]   curve_x,
  output logic signed [cbz_pkg::COORD_W-1:0]   curve_y,

  // config write port
  input  logic                                 cfg_write,
  input  logic [cbz_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cbz_pkg::POINT_W-1:0]          cfg_data
);
  import cbz_pkg::*;

  // control point registers
  point_t x_point [4];
  point_t y_point [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        x_point[k] <= '0;
        y_point[k] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_POINT_0: x_point[0] <= point_t'(cfg_data);
        REG_X_POINT_1: x_point[1] <= point_t'(cfg_data);
        REG_X_POINT_2: x_point[2] <= point_t'(cfg_data);
        REG_X_POINT_3: x_point[3] <= point_t'(cfg_data);
        REG_Y_POINT_0: y_point[0] <= point_t'(cfg_data);
        REG_Y_POINT_1: y_point[1] <= point_t'(cfg_data);
        REG_Y_POINT_2: y_point[2] <= point_t'(cfg_data);
        REG_Y_POINT_3: y_point[3] <= point_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] valid_shift;
  stage_en_t             stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = ~stage_valid[NUM_STAGES-1] | result_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = ~stage_valid[k] | stage_en[k+1];
    end
  end

  assign valid_shift = {stage_valid[NUM_STAGES-2:0], sample_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= valid_shift[k];
        end
      end
    end
  end

  assign sample_ready = stage_en[0];
  assign result_valid = stage_valid[NUM_STAGES-1];

  // one datapath per axis, both driven by the same stage enables
  cbz_axis #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_axis_x (
    .clk    (clk),
    .en     (stage_en),
    .sample (sample_index),
    .p0     (x_point[0]),
    .p1     (x_point[1]),
    .p2     (x_point[2]),
    .p3     (x_point[3]),
    .coord  (curve_x)
  );

  cbz_axis #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_axis_y (
    .clk    (clk),
    .en     (stage_en),
    .sample (sample_index),
    .p0     (y_point[0]),
    .p1     (y_point[1]),
    .p2     (y_point[2]),
    .p3     (y_point[3]),
    .coord  (curve_y)
  );

  // input only backs up when every stage holds a sample
  a_ready_only_when_full : assert property (
    @(posedge clk) disable iff (rst)
    !sample_ready |-> (&stage_valid)
  ) else $error("sample_ready low with an empty pipeline stage");

  // an accepted sample lands in the input stage
  a_accept_fills_stage0 : assert property (
    @(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> stage_valid[0]
  ) else $error("accepted sample lost at the input stage");

  // a stalled stage keeps its sample
  a_stall_holds : assert property (
    @(posedge clk) disable iff (rst)
    ((stage_valid & ~stage_en) != '0) |=>
      ((stage_valid & $past(stage_valid & ~stage_en)) == $past(stage_valid & ~stage_en))
  ) else $error("stalled pipeline stage dropped its sample");

endmodule

/* rtl/cbz_axis.sv */
// ----------------------------------------------------------------------------
// cbz_axis - one coordinate of the bezier evaluator
// Horner evaluation of the power-basis cubic in the sample index, exact,
// with each multiply and each add in a register stage of its own.
// ----------------------------------------------------------------------------
module cbz_axis #(
  parameter int SAMPLE_BITS = 19
) (
  input  logic                                clk,
  input  cbz_pkg::stage_en_t                  en,
  input  logic [SAMPLE_BITS-1:0]              sample,
  input  cbz_pkg::point_t                     p0,
  input  cbz_pkg::point_t                     p1,
  input  cbz_pkg::point_t                     p2,
  input  cbz_pkg::point_t                     p3,
  output logic signed [cbz_pkg::COORD_W-1:0]  coord
);
  import cbz_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int CW    = MUL_CHUNK_W;
  localparam int H1W   = S + 21;
  localparam int H2W   = 2 * S + 22;
  localparam int H3W   = 3 * S + 16;
  localparam int NC1   = (H1W + CW - 1) / CW;
  localparam int NC2   = (H2W + CW - 1) / CW;
  localparam int PW    = CW + S + 2;
  localparam int ACC1W = NC1 * CW + S + 2;
  localparam int ACC2W = NC2 * CW + S + 2;

  // power-basis coefficients
  logic signed [COEF_W-1:0] p0e, p1e, p2e, p3e;
  logic signed [COEF_W-1:0] d1, d2;
  logic signed [COEF_W-1:0] a1, a2, a3;

  assign p0e = COEF_W'(p0);
  assign p1e = COEF_W'(p1);
  assign p2e = COEF_W'(p2);
  assign p3e = COEF_W'(p3);
  assign d1  = p1e - p0e;
  assign d2  = p0e - (p1e <<< 1) + p2e;
  assign a1  = (d1 <<< 1) + d1;
  assign a2  = (d2 <<< 1) + d2;
  assign a3  = p3e - p2e - (p2e <<< 1) + p1e + (p1e <<< 1) - p0e;

  // sample index travels alongside
  logic [S-1:0] i0, i1, i2, i3, i4;

  logic signed [H1W-1:0] m1;
  logic signed [H1W-1:0] h1;
  logic signed [PW-1:0]  pp1 [NC1];
  logic signed [H2W-1:0] h2;
  logic signed [PW-1:0]  pp2 [NC2];
  logic signed [H3W-1:0] h3;

  logic signed [NC1*CW-1:0] h1x;
  logic signed [NC2*CW-1:0] h2x;
  logic signed [CW:0]       ch1 [NC1];
  logic signed [CW:0]       ch2 [NC2];
  logic signed [ACC1W-1:0]  acc1;
  logic signed [ACC2W-1:0]  acc2;

  // chunk the multiplicands: low chunks unsigned, top chunk carries the sign
  always_comb begin
    h1x = (NC1 * CW)'(h1);
    for (int k = 0; k < NC1; k++) begin
      if (k == NC1 - 1) begin
        ch1[k] = $signed({h1x[NC1*CW-1], h1x[k*CW +: CW]});
      end else begin
        ch1[k] = $signed({1'b0, h1x[k*CW +: CW]});
      end
    end
  end

  always_comb begin
    h2x = (NC2 * CW)'(h2);
    for (int k = 0; k < NC2; k++) begin
      if (k == NC2 - 1) begin
        ch2[k] = $signed({h2x[NC2*CW-1], h2x[k*CW +: CW]});
      end else begin
        ch2[k] = $signed({1'b0, h2x[k*CW +: CW]});
      end
    end
  end

  // recombine partial products and add the next coefficient
  always_comb begin
    acc1 = ACC1W'(a1) <<< (2 * S);
    for (int k = 0; k < NC1; k++) begin
      acc1 = acc1 + (ACC1W'(pp1[k]) <<< (k * CW));
    end
  end

  always_comb begin
    acc2 = ACC2W'(p0) <<< (3 * S);
    for (int k = 0; k < NC2; k++) begin
      acc2 = acc2 + (ACC2W'(pp2[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      i0 <= sample;
    end
    if (en[1]) begin
      i1 <= i0;
      m1 <= H1W'(a3) * H1W'($signed({1'b0, i0}));
    end
    if (en[2]) begin
      i2 <= i1;
      h1 <= m1 + (H1W'(a2) <<< S);
    end
    if (en[3]) begin
      i3 <= i2;
      for (int k = 0; k < NC1; k++) begin
        pp1[k] <= PW'(ch1[k]) * PW'($signed({1'b0, i2}));
      end
    end
    if (en[4]) begin
      i4 <= i3;
      h2 <= $signed(acc1[H2W-1:0]);
    end
    if (en[5]) begin
      for (int k = 0; k < NC2; k++) begin
        pp2[k] <= PW'(ch2[k]) * PW'($signed({1'b0, i4}));
      end
    end
    if (en[6]) begin
      h3 <= $signed(acc2[H3W-1:0]);
    end
  end

  // sum carries 3*S fraction bits; pick Q16.16 (floor by truncation)
  generate
    if (H3W >= COORD_W) begin : g_trunc
      assign coord = h3[H3W-1 -: COORD_W];
    end else begin : g_pad
      assign coord = {h3, {(COORD_W - H3W){1'b0}}};
    end
  endgenerate

endmodule

/* bench/cubic_bezier_point_eval_tb.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_tb - self-checking bench of the bezier evaluator
// Programs control points through the config port, then sends a directed
// table of curve samples and about fourteen hundred random ones. Each result
// is checked against a typed expectation from the table or an exact integer
// model of the curve, under random gaps on the sample and the result side.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_tb;

  import cbz_pkg::*;

  localparam int SAMPLE_BITS = 19;

  // generous run limit, far above the slowest correct run
  localparam int RUN_LIMIT = 4_000_000;

  // random part: three idle profiles, three point settings each
  localparam int BLOCKS_PER_MODE = 3;
  localparam int SAMPLES_PER_BLOCK = 160;

  localparam logic [POINT_W-1:0] PMAX = 16'h7FFF;
  localparam logic [POINT_W-1:0] PMIN = 16'h8000;

  // a whole curve at one extreme point comes out as that point in Q16.16
  localparam logic signed [COORD_W-1:0] TOP_Q16 = 32'sh7FFF0000;
  localparam logic signed [COORD_W-1:0] BOT_Q16 = 32'sh80000000;

  typedef enum logic [0:0] {
    ROW_POINTS,
    ROW_SAMPLE
  } row_kind_t;

  // one row of the directed table; pts holds register k in slice k
  typedef struct packed {
    row_kind_t                     kind;
    logic [7:0][POINT_W-1:0]       pts;
    logic [SAMPLE_BITS-1:0]        index;
    logic                          typed;
    logic signed [COORD_W-1:0]     tx;
    logic signed [COORD_W-1:0]     ty;
  } stim_row_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_pair_t;

  localparam int DIR_ROWS = 24;

  // point rows list the registers from y_point_3 down to x_point_0
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // registers straight out of reset: every point is the origin
    '{ROW_SAMPLE, '0, 19'h00000, 1'b1, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h7FFFF, 1'b1, 32'sd0, 32'sd0},
    // all x at the top, all y at the bottom: the curve is one point
    '{ROW_POINTS, {PMIN, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX},
      '0, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h00000, 1'b1, TOP_Q16, BOT_Q16},
    '{ROW_SAMPLE, '0, 19'h00001, 1'b1, TOP_Q16, BOT_Q16},
    '{ROW_SAMPLE, '0, 19'h40000, 1'b1, TOP_Q16, BOT_Q16},
    '{ROW_SAMPLE, '0, 19'h7FFFF, 1'b1, TOP_Q16, BOT_Q16},
    '{ROW_SAMPLE, '0, 19'h2AAAA, 1'b1, TOP_Q16, BOT_Q16},
    '{ROW_SAMPLE, '0, 19'h55555, 1'b1, TOP_Q16, BOT_Q16},
    // alternating extremes: widest swing of the weighted sum
    '{ROW_POINTS, {PMIN, PMAX, PMIN, PMAX, PMAX, PMIN, PMAX, PMIN},
      '0, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h00000, 1'b1, BOT_Q16, TOP_Q16},
    '{ROW_SAMPLE, '0, 19'h00001, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h00002, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h40000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h7FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h7FFFE, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h12345, 1'b0, 32'sd0, 32'sd0},
    // small mixed-sign points, fractions that floor below zero
    '{ROW_POINTS, {16'sd5, 16'sd1, 16'sd0, -16'sd1,
                   -16'sd400, 16'sd300, -16'sd200, 16'sd100},
      '0, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h00000, 1'b1, 32'sd6553600, -32'sd65536},
    '{ROW_SAMPLE, '0, 19'h7FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h3FFFF, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h00001, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h60000, 1'b0, 32'sd0, 32'sd0},
    '{ROW_SAMPLE, '0, 19'h1FFFF, 1'b0, 32'sd0, 32'sd0}
  };

  logic clk;
  logic rst = 1'b1;

  logic                          sample_valid = 1'b0;
  logic                          sample_ready;
  logic [SAMPLE_BITS-1:0]        sample_index = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic signed [COORD_W-1:0]     curve_x;
  logic signed [COORD_W-1:0]     curve_y;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [POINT_W-1:0]            cfg_data = '0;

  // typed expectation riding along with the current sample transfer
  logic                          row_typed = 1'b0;
  logic signed [COORD_W-1:0]     row_tx = '0;
  logic signed [COORD_W-1:0]     row_ty = '0;

  // bench copy of the control point registers
  point_t ctl_x [4] = '{default: '0};
  point_t ctl_y [4] = '{default: '0};

  point_pair_t pending_points [$];

  int send_idle_pct = 7;
  int recv_idle_pct = 65;
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int point_settings = 0;

  cubic_bezier_point_eval #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_index(sample_index),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // exact curve coordinate: bernstein weights scaled by 2^(3*SAMPLE_BITS),
  // weighted sum in wide signed integers, then floored into Q16.16
  function automatic logic signed [COORD_W-1:0] bezier_coord(
    input logic [SAMPLE_BITS-1:0] idx,
    input point_t p0, input point_t p1, input point_t p2, input point_t p3
  );
    logic signed [127:0] t_num, u_num, q0, q1, q2, q3, acc;
    int sh;
    t_num = 128'(idx);
    u_num = (128'sd1 <<< SAMPLE_BITS) - t_num;
    q0 = p0;
    q1 = p1;
    q2 = p2;
    q3 = p3;
    acc = u_num * u_num * u_num * q0
        + 128'sd3 * t_num * u_num * u_num * q1
        + 128'sd3 * t_num * t_num * u_num * q2
        + t_num * t_num * t_num * q3;
    sh = 3 * SAMPLE_BITS - 16;
    // arithmetic shift right floors toward minus infinity
    if (sh >= 0) begin
      acc = acc >>> sh;
    end else begin
      acc = acc <<< (-sh);
    end
    return acc[COORD_W-1:0];
  endfunction

  // sample index biased toward the ends of the curve and single bits
  function automatic logic [SAMPLE_BITS-1:0] pick_index();
    logic [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    case ($urandom_range(5))
      0: v = SAMPLE_BITS'($urandom_range(15));
      1: v = ~SAMPLE_BITS'($urandom_range(15));
      2: v = SAMPLE_BITS'(1) << $urandom_range(SAMPLE_BITS - 1);
      3: v = ~(SAMPLE_BITS'(1) << $urandom_range(SAMPLE_BITS - 1));
      default: ;
    endcase
    return v;
  endfunction

  // control point value, an extreme, zero or all ones about a quarter of the time
  function automatic logic [POINT_W-1:0] pick_point();
    logic [POINT_W-1:0] v;
    v = POINT_W'($urandom);
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: v = PMAX;
        1: v = PMIN;
        2: v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  // result side: random backpressure per the current idle profile
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard: queue the expectation on each sample transfer, compare on
  // each result transfer
  always @(posedge clk) begin
    point_pair_t want;
    if (!rst && sample_valid && sample_ready) begin
      if (row_typed) begin
        want.x = row_tx;
        want.y = row_ty;
      end else begin
        want.x = bezier_coord(sample_index, ctl_x[0], ctl_x[1], ctl_x[2], ctl_x[3]);
        want.y = bezier_coord(sample_index, ctl_y[0], ctl_y[1], ctl_y[2], ctl_y[3]);
      end
      pending_points.push_back(want);
      samples_sent++;
    end
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing pending, got x %0d y %0d",
                 $time, curve_x, curve_y);
      end else begin
        want = pending_points.pop_front();
        if (curve_x !== want.x) begin
          mismatch_count++;
          $display("%0t: curve_x mismatch, expected %0d got %0d",
                   $time, want.x, curve_x);
        end
        if (curve_y !== want.y) begin
          mismatch_count++;
          $display("%0t: curve_y mismatch, expected %0d got %0d",
                   $time, want.y, curve_y);
        end
      end
    end
  end

  // one sample transfer; valid stays up from one sample to the next unless
  // a random gap or a drain lowers it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] idx, input logic typed,
                             input logic signed [COORD_W-1:0] tx,
                             input logic signed [COORD_W-1:0] ty);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_index <= idx;
    row_typed    <= typed;
    row_tx       <= tx;
    row_ty       <= ty;
    do @(posedge clk); while (!sample_ready);
  endtask

  // stop sending and wait until every pending result has come back
  task automatic drain();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // write all eight point registers back to back, pipeline must be empty
  task automatic write_points(input logic [7:0][POINT_W-1:0] pts);
    cfg_reg_t addr;
    for (int k = 0; k <= int'(REG_Y_POINT_3); k++) begin
      addr = cfg_reg_t'(k);
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= addr;
      cfg_data  <= pts[k];
      case (addr)
        REG_X_POINT_0: ctl_x[0] = pts[k];
        REG_X_POINT_1: ctl_x[1] = pts[k];
        REG_X_POINT_2: ctl_x[2] = pts[k];
        REG_X_POINT_3: ctl_x[3] = pts[k];
        REG_Y_POINT_0: ctl_y[0] = pts[k];
        REG_Y_POINT_1: ctl_y[1] = pts[k];
        REG_Y_POINT_2: ctl_y[2] = pts[k];
        REG_Y_POINT_3: ctl_y[3] = pts[k];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    point_settings++;
  endtask

  initial begin
    logic [7:0][POINT_W-1:0] rand_pts;
    int send_pcts [3];
    int recv_pcts [3];
    send_pcts = '{7, 65, 0};
    recv_pcts = '{65, 7, 0};

    // reset held from time zero, released on a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed table: point rows wait for an empty pipeline first
    foreach (DIR_TABLE[r]) begin
      if (DIR_TABLE[r].kind == ROW_POINTS) begin
        drain();
        write_points(DIR_TABLE[r].pts);
      end else begin
        send_sample(DIR_TABLE[r].index, DIR_TABLE[r].typed,
                    DIR_TABLE[r].tx, DIR_TABLE[r].ty);
      end
    end

    // random part: sender-light, then receiver-light, then no idling
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_pcts[m];
      recv_idle_pct = recv_pcts[m];
      for (int b = 0; b < BLOCKS_PER_MODE; b++) begin
        drain();
        for (int k = 0; k < 8; k++) begin
          rand_pts[k] = pick_point();
        end
        write_points(rand_pts);
        for (int n = 0; n < SAMPLES_PER_BLOCK; n++) begin
          // hold off mid-block once per profile until the pipeline empties
          if (b == 0 && n == SAMPLES_PER_BLOCK / 2) begin
            drain();
          end
          send_sample(pick_index(), 1'b0, '0, '0);
        end
      end
    end

    // let the last results out, then watch for stray ones
    drain();
    repeat (4 * NUM_STAGES) @(posedge clk);

    $display("covered %0d curve samples over %0d control point settings,",
             samples_sent, point_settings);
    $display("%0d results checked under three idle profiles", results_seen);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
